// ===== rtl/core/mmn_pkg.sv =====
// Package for the min-max normalizer: widths, output packing and the
// divider request/response types. No dependencies.
package mmn_pkg;

    // Sample and fraction widths fixed by the stream format
    localparam int SAMPLE_BITS   = 32;
    localparam int FRACTION_BITS = 16;
    localparam int NORM_W        = FRACTION_BITS + 1;
    localparam int INDEX_W       = 6;
    localparam int STEP_W        = $clog2(FRACTION_BITS + 1);

    // Output beat packing: tdata = {pad, item_index, norm_value}
    localparam int OUT_DATA_W    = ((NORM_W + INDEX_W + 7) / 8) * 8;
    localparam int OUT_PAD_W     = OUT_DATA_W - NORM_W - INDEX_W;
    localparam int OUT_USER_W    = 2;

    // Value that stands for exactly 1.0
    localparam logic [NORM_W-1:0] NORM_ONE = NORM_W'(1) << FRACTION_BITS;

    // Request into the shared divider
    typedef struct packed {
        logic                   start;
        logic [SAMPLE_BITS-1:0] num;
        logic [SAMPLE_BITS-1:0] den;
    } t_div_req;

    // Status out of the shared divider
    typedef struct packed {
        logic              busy;
        logic [NORM_W-1:0] quot;
    } t_div_rsp;

endpackage

// ===== rtl/core/mmn_div.sv =====
// Restoring fraction divider, one quotient bit per cycle.
// Depends on mmn_pkg for widths and the request/response types.
module mmn_div
    import mmn_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                   r_busy;
    logic [STEP_W-1:0]      r_step;
    logic [SAMPLE_BITS-1:0] r_rem;
    logic [SAMPLE_BITS-1:0] r_den;
    logic [NORM_W-1:0]      r_quot;

    logic [SAMPLE_BITS:0]   w_shift;
    logic [SAMPLE_BITS:0]   w_diff;
    logic                   w_fit;

    // One restoring step: shift the remainder, try to subtract
    assign w_shift = {r_rem, 1'b0};
    assign w_diff  = w_shift - {1'b0, r_den};
    assign w_fit   = (w_shift >= {1'b0, r_den});

    // Control: busy while quotient bits are still being produced
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_req.start) begin
            r_busy <= (i_req.den != '0) && (i_req.num < i_req.den);
            r_step <= STEP_W'(FRACTION_BITS);
        end else if (r_busy) begin
            r_step <= r_step - STEP_W'(1);
            if (r_step == STEP_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath: zero range gives 0, num >= den gives 1.0
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.num;
            r_den <= i_req.den;
            if (i_req.den == '0) begin
                r_quot <= '0;
            end else if (i_req.num >= i_req.den) begin
                r_quot <= NORM_ONE;
            end else begin
                r_quot <= '0;
            end
        end else if (r_busy) begin
            r_rem  <= w_fit ? w_diff[SAMPLE_BITS-1:0] : w_shift[SAMPLE_BITS-1:0];
            r_quot <= {r_quot[NORM_W-2:0], w_fit};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.quot = r_quot;

endmodule

// ===== rtl/core/min_max_normalizer_top.sv =====
// Min-max normalizer top level: batch loader, sample memory, sequencer
// and output register. Depends on mmn_pkg and mmn_div.
//
// Usage:
// The slave channel takes one sample per beat: tdata holds the signed
// sample, tuser the missing flag, tlast closes the batch. Loading runs at
// one beat per cycle. On the closing beat the input stops (tready low),
// unless the batch is empty, and the block emits one beat per stored sample
// on the master channel: tdata = {item_index, norm_value}, tuser =
// {overflow, error}, tlast on the final result. A batch with a missing item
// gives a single error beat; an empty batch gives none. Up to MAX_ITEMS
// samples are kept; later ones are dropped and flag overflow.
// Each result passes through the memory read, the offset subtract, the
// shared restoring divider at one quotient bit per cycle and the load of
// the output register. A zero range or the batch maximum skips the divider.
// A result waits in the output register while the receiver stalls; the
// next division runs meanwhile and then holds. Input is taken again once
// the last result sits in the output register. Reset (synchronous, active
// low) empties the batch and the output.
module min_max_normalizer_top
    import mmn_pkg::*;
#(
    parameter int MAX_ITEMS = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Slave side
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [SAMPLE_BITS-1:0] i_s_axis_tdata,  // [31:0] sample
    input  logic                   i_s_axis_tuser,  // [0] missing
    input  logic                   i_s_axis_tlast,  // batch_end
    // Master side
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_DATA_W-1:0]  o_m_axis_tdata,  // [16:0] norm_value, [22:17] item_index
    output logic [OUT_USER_W-1:0]  o_m_axis_tuser,  // [0] error, [1] overflow
    output logic                   o_m_axis_tlast   // run_last
);

    localparam int ADDR_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int EXT_W  = ADDR_W + INDEX_W;

    localparam logic [2:0] ST_LOAD = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_SUB  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_ERR  = 3'd4;

    localparam logic signed [SAMPLE_BITS-1:0] MAX_VAL = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] MIN_VAL = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic [2:0]                     r_state, n_state;
    logic [CNT_W-1:0]               r_count, n_count;
    logic signed [SAMPLE_BITS-1:0]  r_min, n_min;
    logic signed [SAMPLE_BITS-1:0]  r_max, n_max;
    logic                           r_err, n_err;
    logic                           r_ovf, n_ovf;
    logic [ADDR_W-1:0]              r_idx, n_idx;
    logic [SAMPLE_BITS-1:0]         r_range;
    logic [SAMPLE_BITS-1:0]         r_rd;

    logic                           r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0]          r_out_data, n_out_data;
    logic [OUT_USER_W-1:0]          r_out_user, n_out_user;
    logic                           r_out_last, n_out_last;

    logic [SAMPLE_BITS-1:0]         mem [MAX_ITEMS];

    logic                           w_in_take;
    logic                           w_store;
    logic                           w_slot_free;
    logic                           w_final;
    logic [EXT_W-1:0]               w_idx_ext;
    logic signed [SAMPLE_BITS-1:0]  w_sample;
    t_div_req                       w_req;
    t_div_rsp                       w_rsp;

    assign w_sample    = i_s_axis_tdata;
    assign w_in_take   = i_s_axis_tvalid && (r_state == ST_LOAD);
    assign w_store     = w_in_take && !i_s_axis_tuser && (r_count != CNT_W'(MAX_ITEMS));
    assign w_slot_free = !r_out_valid || i_m_axis_tready;
    assign w_final     = (CNT_W'(r_idx) + CNT_W'(1)) == r_count;
    assign w_idx_ext   = EXT_W'(r_idx);

    // Shared divider
    assign w_req.start = (r_state == ST_SUB);
    assign w_req.num   = r_rd - r_min;
    assign w_req.den   = r_range;

    mmn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // Sample memory: write on load, registered read at the result index
    always_ff @(posedge i_clk) begin
        if (w_store) begin
            mem[r_count[ADDR_W-1:0]] <= i_s_axis_tdata;
        end
        r_rd <= mem[r_idx];
    end

    // Range of the closed batch
    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ) begin
            r_range <= r_max - r_min;
        end
    end

    // Sequencer and batch tracking
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_min       = r_min;
        n_max       = r_max;
        n_err       = r_err;
        n_ovf       = r_ovf;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_data  = r_out_data;
        n_out_user  = r_out_user;
        n_out_last  = r_out_last;

        case (r_state)
            ST_LOAD: begin
                if (w_in_take) begin
                    if (i_s_axis_tuser) begin
                        n_err = 1'b1;
                    end else if (r_count == CNT_W'(MAX_ITEMS)) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                        if (w_sample < r_min) begin
                            n_min = w_sample;
                        end
                        if (w_sample > r_max) begin
                            n_max = w_sample;
                        end
                    end
                    // Close the batch
                    if (i_s_axis_tlast) begin
                        n_idx = '0;
                        if (n_err) begin
                            n_state = ST_ERR;
                        end else if (n_count == '0) begin
                            n_min = MAX_VAL;
                            n_max = MIN_VAL;
                            n_ovf = 1'b0;
                        end else begin
                            n_state = ST_READ;
                        end
                    end
                end
            end
            ST_READ: begin
                n_state = ST_SUB;
            end
            ST_SUB: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (!w_rsp.busy && w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {{OUT_PAD_W{1'b0}}, w_idx_ext[INDEX_W-1:0], w_rsp.quot};
                    n_out_user  = {r_ovf, 1'b0};
                    n_out_last  = w_final;
                    if (w_final) begin
                        n_state = ST_LOAD;
                        n_count = '0;
                        n_min   = MAX_VAL;
                        n_max   = MIN_VAL;
                        n_ovf   = 1'b0;
                    end else begin
                        n_idx   = r_idx + ADDR_W'(1);
                        n_state = ST_READ;
                    end
                end
            end
            ST_ERR: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = '0;
                    n_out_user  = {r_ovf, 1'b1};
                    n_out_last  = 1'b1;
                    n_state     = ST_LOAD;
                    n_count     = '0;
                    n_min       = MAX_VAL;
                    n_max       = MIN_VAL;
                    n_err       = 1'b0;
                    n_ovf       = 1'b0;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_min       <= MAX_VAL;
            r_max       <= MIN_VAL;
            r_err       <= 1'b0;
            r_ovf       <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_min       <= n_min;
            r_max       <= n_max;
            r_err       <= n_err;
            r_ovf       <= n_ovf;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
        r_out_last <= n_out_last;
    end

    assign o_s_axis_tready = (r_state == ST_LOAD);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;
    assign o_m_axis_tlast  = r_out_last;

endmodule

// ===== bench/mmn_checker.sv =====
// Scoreboard for the min-max normalizer: watches both stream channels,
// predicts each batch's result beats and compares them. Depends on mmn_pkg.
`timescale 1ns / 1ps

module mmn_checker
    import mmn_pkg::*;
#(
    parameter int MAX_ITEMS = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Slave channel as seen at the block
    input  logic                   i_s_tvalid,
    input  logic                   i_s_tready,
    input  logic [SAMPLE_BITS-1:0] i_s_tdata,   // [31:0] sample
    input  logic                   i_s_tuser,   // [0] missing
    input  logic                   i_s_tlast,   // batch_end
    // Master channel as seen at the block
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [OUT_DATA_W-1:0]  i_m_tdata,   // [16:0] norm_value, [22:17] item_index
    input  logic [OUT_USER_W-1:0]  i_m_tuser,   // [0] error, [1] overflow
    input  logic                   i_m_tlast,   // run_last
    output int                     o_mismatches,
    output int                     o_pending,
    output int                     o_results
);

    localparam int ERR_BIT = 0;
    localparam int OVF_BIT = 1;
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef struct packed {
        logic [NORM_W-1:0]  norm_value;
        logic [INDEX_W-1:0] item_index;
        logic               run_last;
        logic               error;
        logic               overflow;
    } t_norm_beat;

    // Results still owed by the block, oldest first
    t_norm_beat pending_results[$];

    // Running batch state
    logic signed [SAMPLE_BITS-1:0] batch_samples [MAX_ITEMS];
    int                            batch_len;
    logic signed [SAMPLE_BITS-1:0] batch_lo;
    logic signed [SAMPLE_BITS-1:0] batch_hi;
    logic                          batch_err;
    logic                          batch_ovf;

    int mismatches   = 0;
    int results_seen = 0;

    // Q1.16 fraction offs / span, truncated; offs never exceeds span
    function automatic logic [NORM_W-1:0] q_fraction(input longint offs, input longint span);
        longint q;
        if (offs >= span)
            return NORM_ONE;
        q = (offs << FRACTION_BITS) / span;
        return q[NORM_W-1:0];
    endfunction

    task automatic clear_batch();
        batch_len = 0;
        batch_lo  = SAMPLE_MAX;
        batch_hi  = SAMPLE_MIN;
        batch_err = 1'b0;
        batch_ovf = 1'b0;
    endtask

    // Fold one input beat into the batch; on the closing beat queue its results
    task automatic absorb_beat(input logic signed [SAMPLE_BITS-1:0] smp, input logic miss,
                               input logic close);
        t_norm_beat res;
        longint     span;
        if (miss) begin
            batch_err = 1'b1;
        end else if (batch_len >= MAX_ITEMS) begin
            batch_ovf = 1'b1;
        end else begin
            batch_samples[batch_len] = smp;
            batch_len++;
            if (smp < batch_lo)
                batch_lo = smp;
            if (smp > batch_hi)
                batch_hi = smp;
        end
        if (!close)
            return;
        if (batch_err) begin
            // A missing item collapses the batch to one error beat
            res = '{norm_value: '0, item_index: '0, run_last: 1'b1, error: 1'b1,
                    overflow: batch_ovf};
            pending_results.insert(pending_results.size(), res);
        end else begin
            span = longint'(batch_hi) - longint'(batch_lo);
            for (int k = 0; k < batch_len; k++) begin
                res.norm_value = (span == 0) ? '0 :
                    q_fraction(longint'(batch_samples[k]) - longint'(batch_lo), span);
                res.item_index = INDEX_W'(k);
                res.run_last   = (k == batch_len - 1);
                res.error      = 1'b0;
                res.overflow   = batch_ovf;
                pending_results.insert(pending_results.size(), res);
            end
        end
        clear_batch();
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Compare one result beat against the oldest expectation
    task automatic check_result();
        t_norm_beat want;
        results_seen++;
        if (pending_results.size() == 0) begin
            $error("result beat with nothing expected: tdata=%h tuser=%b tlast=%b",
                   i_m_tdata, i_m_tuser, i_m_tlast);
            mismatches++;
            return;
        end
        want = pending_results.pop_front();
        check_field("norm_value", want.norm_value, i_m_tdata[NORM_W-1:0]);
        check_field("item_index", want.item_index, i_m_tdata[NORM_W+INDEX_W-1:NORM_W]);
        check_field("run_last", want.run_last, i_m_tlast);
        check_field("error", want.error, i_m_tuser[ERR_BIT]);
        check_field("overflow", want.overflow, i_m_tuser[OVF_BIT]);
    endtask

    // Sample both channels at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_batch();
        end else begin
            if (i_m_tvalid && i_m_tready)
                check_result();
            if (i_s_tvalid && i_s_tready)
                absorb_beat(i_s_tdata, i_s_tuser, i_s_tlast);
        end
        o_mismatches <= mismatches;
        o_pending    <= pending_results.size();
        o_results    <= results_seen;
    end

endmodule

// ===== bench/tb_min_max_normalizer_top.sv =====
// Top of the min-max normalizer bench: clock, reset, batch stimulus and
// verdict. Depends on mmn_pkg, min_max_normalizer_top and mmn_checker.
`timescale 1ns / 1ps

module tb_min_max_normalizer_top;
    import mmn_pkg::*;

    localparam int MAX_ITEMS   = 64;
    localparam int ITEM_TARGET = 420;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 60;

    // Sample value shapes for a batch
    localparam int STYLE_WIDE    = 0;
    localparam int STYLE_CLUSTER = 1;
    localparam int STYLE_FLAT    = 2;
    localparam int STYLE_EDGE    = 3;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [SAMPLE_BITS-1:0] s_tdata;   // [31:0] sample
    logic                   s_tuser;   // [0] missing
    logic                   s_tlast;   // batch_end
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;   // [16:0] norm_value, [22:17] item_index
    logic [OUT_USER_W-1:0]  m_tuser;   // [0] error, [1] overflow
    logic                   m_tlast;   // run_last

    int mismatches;
    int pending;
    int results;
    int cycles      = 0;
    int items_sent  = 0;
    int batches     = 0;
    int snd_idle    = 8;
    int rcv_idle    = 47;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    min_max_normalizer_top #(
        .MAX_ITEMS(MAX_ITEMS)
    ) uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(s_tvalid),
        .o_s_axis_tready(s_tready),
        .i_s_axis_tdata (s_tdata),
        .i_s_axis_tuser (s_tuser),
        .i_s_axis_tlast (s_tlast),
        .o_m_axis_tvalid(m_tvalid),
        .i_m_axis_tready(m_tready),
        .o_m_axis_tdata (m_tdata),
        .o_m_axis_tuser (m_tuser),
        .o_m_axis_tlast (m_tlast)
    );

    mmn_checker #(
        .MAX_ITEMS(MAX_ITEMS)
    ) checker_i (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .i_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_s_tlast   (s_tlast),
        .i_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .i_m_tdata   (m_tdata),
        .i_m_tuser   (m_tuser),
        .i_m_tlast   (m_tlast),
        .o_mismatches(mismatches),
        .o_pending   (pending),
        .o_results   (results)
    );

    // Receiver back-pressure, redrawn every cycle
    always @(negedge clk) begin
        m_tready <= ($urandom_range(0, 99) >= rcv_idle);
    end

    // Hard stop on a hung run
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Drive one input beat and hold it until the block takes it
    task automatic send_beat(input logic [SAMPLE_BITS-1:0] smp, input logic miss,
                             input logic close);
        while ($urandom_range(0, 99) < snd_idle) begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            s_tuser  <= 1'($urandom_range(0, 1));
            s_tlast  <= 1'($urandom_range(0, 1));
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tuser  <= miss;
        s_tlast  <= close;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
        if (close)
            batches++;
        @(negedge clk);
    endtask

    function automatic logic [SAMPLE_BITS-1:0] pick_sample(input int style,
                                                           input logic [SAMPLE_BITS-1:0] base);
        case (style)
            STYLE_CLUSTER: return base + $urandom_range(0, 255);
            STYLE_FLAT:    return base;
            STYLE_EDGE: begin
                case ($urandom_range(0, 4))
                    0:       return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
                    1:       return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
                    2:       return '0;
                    3:       return '1;
                    default: return $urandom;
                endcase
            end
            default:       return $urandom;
        endcase
    endfunction

    // Step the idle pattern through its three phases by progress
    task automatic set_phase();
        if (items_sent < ITEM_TARGET / 3) begin
            snd_idle = 8;
            rcv_idle = 47;
        end else if (items_sent < 2 * ITEM_TARGET / 3) begin
            snd_idle = 47;
            rcv_idle = 8;
        end else begin
            snd_idle = 0;
            rcv_idle = 0;
        end
    endtask

    initial begin
        int                     len;
        int                     roll;
        int                     miss_at;
        int                     style;
        logic [SAMPLE_BITS-1:0] base;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        s_tlast  = 1'b0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Full-scale extremes: results 0, one and the midpoint
        send_beat(32'h8000_0000, 1'b0, 1'b0);
        send_beat(32'h7FFF_FFFF, 1'b0, 1'b0);
        send_beat(32'h0000_0000, 1'b0, 1'b1);
        // Flat batch: every result is zero
        send_beat(32'd5, 1'b0, 1'b0);
        send_beat(32'd5, 1'b0, 1'b0);
        send_beat(32'd5, 1'b0, 1'b1);
        // Single sample
        send_beat(32'hFFFF_FFFF, 1'b0, 1'b1);
        // Missing item mid-batch, then on the closing beat
        send_beat(32'd10, 1'b0, 1'b0);
        send_beat(32'h1234_5678, 1'b1, 1'b0);
        send_beat(32'd20, 1'b0, 1'b1);
        send_beat(32'd3, 1'b0, 1'b0);
        send_beat(32'd4, 1'b1, 1'b1);
        // Small signed span and alternating bit patterns
        send_beat(32'hFFFF_FFFF, 1'b0, 1'b0);
        send_beat(32'h0000_0001, 1'b0, 1'b0);
        send_beat(32'h0000_0000, 1'b0, 1'b1);
        send_beat(32'hAAAA_AAAA, 1'b0, 1'b0);
        send_beat(32'h5555_5555, 1'b0, 1'b1);

        // Random batches, mostly short, a few past capacity
        while (items_sent < ITEM_TARGET) begin
            set_phase();
            roll = $urandom_range(0, 99);
            if (roll < 85)
                len = $urandom_range(1, 8);
            else if (roll < 97)
                len = $urandom_range(9, 40);
            else
                len = $urandom_range(60, 70);
            if (batches % 16 == 5)
                len = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 6);
            miss_at = ($urandom_range(0, 99) < 10) ? $urandom_range(0, len - 1) : -1;
            style   = $urandom_range(STYLE_WIDE, STYLE_EDGE);
            base    = $urandom;
            for (int i = 0; i < len; i++)
                send_beat(pick_sample(style, base),
                          (i == miss_at) || ($urandom_range(0, 199) == 0),
                          (i == len - 1));
        end
        s_tvalid <= 1'b0;

        // Drain the outstanding results, then watch for strays
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Sent %0d samples in %0d batches over three idle phases;", items_sent, batches);
        $display("checked %0d result beats in %0d cycles.", results, cycles);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
